// ===== design/c2p_pkg.sv =====
package c2p_pkg;

    localparam int COORD_WIDTH_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int FIFO_DEPTH        = 4;

    localparam int GUARD_BITS  = 12;
    localparam int ATAN_FRAC   = 16;
    localparam int ANGLE_FRAC  = 7;
    localparam int ANG_WIDTH   = 16;
    localparam int ATAN_W      = 22;
    localparam int ZW          = 26;
    localparam int AW          = 23;
    localparam int TW          = 25;
    localparam int ANGLE_SHIFT = ATAN_FRAC - ANGLE_FRAC;

    localparam logic [AW-1:0] RIGHT_ANGLE = AW'(90 << ATAN_FRAC);
    localparam logic [TW-1:0] HALF_TURN   = TW'(180 << ATAN_FRAC);
    localparam logic [TW-1:0] FULL_TURN   = TW'(360 << ATAN_FRAC);
    localparam logic [TW-1:0] ANGLE_ROUND = TW'(1 << (ANGLE_SHIFT - 1));
    localparam logic [ANG_WIDTH-1:0] FULL_TURN_OUT = ANG_WIDTH'(360 << ANGLE_FRAC);

    localparam int GAIN_FRAC  = 30;
    localparam int GAIN_SPLIT = 15;
    localparam int GAIN_Q30   = 652032874;
    localparam logic [GAIN_SPLIT-1:0] GAIN_HI = GAIN_SPLIT'(GAIN_Q30 >> GAIN_SPLIT);
    localparam logic [GAIN_SPLIT-1:0] GAIN_LO = GAIN_SPLIT'(GAIN_Q30 % (1 << GAIN_SPLIT));
    localparam int MAG_SHIFT  = GAIN_FRAC - GAIN_SPLIT + GUARD_BITS;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_XAXIS,
        KIND_YAXIS,
        KIND_CORDIC
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  dx_neg;
        logic  dy_neg;
    } t_class;

    // atan(2^-idx) in degrees, 16 fraction bits
    function automatic logic [ATAN_W-1:0] atan_q16(input int idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            0:       v = ATAN_W'(2949120);
            1:       v = ATAN_W'(1740967);
            2:       v = ATAN_W'(919879);
            3:       v = ATAN_W'(466945);
            4:       v = ATAN_W'(234379);
            5:       v = ATAN_W'(117305);
            6:       v = ATAN_W'(58666);
            7:       v = ATAN_W'(29335);
            8:       v = ATAN_W'(14668);
            9:       v = ATAN_W'(7334);
            10:      v = ATAN_W'(3667);
            11:      v = ATAN_W'(1833);
            12:      v = ATAN_W'(917);
            13:      v = ATAN_W'(458);
            14:      v = ATAN_W'(229);
            15:      v = ATAN_W'(115);
            16:      v = ATAN_W'(57);
            17:      v = ATAN_W'(29);
            18:      v = ATAN_W'(14);
            19:      v = ATAN_W'(7);
            20:      v = ATAN_W'(4);
            21:      v = ATAN_W'(2);
            22:      v = ATAN_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/c2p_front.sv =====
module c2p_front #(
    parameter int COORD_WIDTH = c2p_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output c2p_pkg::t_class               o_cls,
    output logic [COORD_WIDTH-1:0]        o_ax,
    output logic [COORD_WIDTH-1:0]        o_ay
);
    import c2p_pkg::*;

    logic signed [COORD_WIDTH:0] dx, dy, ndx, ndy;
    logic [COORD_WIDTH-1:0]      ax, ay;
    t_class                      cls;

    logic                   r_valid;
    t_class                 r_cls;
    logic [COORD_WIDTH-1:0] r_ax, r_ay;

    always_comb begin
        dx  = {i_end_x[COORD_WIDTH-1], i_end_x} - {i_start_x[COORD_WIDTH-1], i_start_x};
        dy  = {i_end_y[COORD_WIDTH-1], i_end_y} - {i_start_y[COORD_WIDTH-1], i_start_y};
        ndx = -dx;
        ndy = -dy;
        ax  = dx[COORD_WIDTH] ? ndx[COORD_WIDTH-1:0] : dx[COORD_WIDTH-1:0];
        ay  = dy[COORD_WIDTH] ? ndy[COORD_WIDTH-1:0] : dy[COORD_WIDTH-1:0];
        cls.dx_neg = dx[COORD_WIDTH];
        cls.dy_neg = dy[COORD_WIDTH];
        if (ax == '0 && ay == '0) begin
            cls.kind = KIND_ZERO;
        end else if (ay == '0) begin
            cls.kind = KIND_XAXIS;
        end else if (ax == '0) begin
            cls.kind = KIND_YAXIS;
        end else begin
            cls.kind = KIND_CORDIC;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cls <= cls;
            r_ax  <= ax;
            r_ay  <= ay;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;
    assign o_ax    = r_ax;
    assign o_ay    = r_ay;

endmodule

// ===== design/c2p_fifo.sv =====
module c2p_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = c2p_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_ready = (r_count != NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/c2p_back.sv =====
module c2p_back #(
    parameter int COORD_WIDTH   = c2p_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  c2p_pkg::t_class               i_cls,
    input  logic [COORD_WIDTH-1:0]        i_ax,
    input  logic [COORD_WIDTH-1:0]        i_ay,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [COORD_WIDTH:0]          o_magnitude,
    output logic [c2p_pkg::ANG_WIDTH-1:0] o_angle,
    output logic                          o_zero
);
    import c2p_pkg::*;

    localparam int DW = COORD_WIDTH + GUARD_BITS + 3;
    localparam int HW = DW - 1 + GAIN_SPLIT;
    localparam int PW = HW + 1;
    localparam int MW = COORD_WIDTH + 1;
    localparam int N  = CORDIC_STAGES;

    logic                   en;

    logic                   r_v [0:N];
    logic signed [DW-1:0]   r_x [0:N];
    logic signed [DW-1:0]   r_y [0:N];
    logic signed [ZW-1:0]   r_z [0:N];
    t_class                 r_c [0:N];
    logic [COORD_WIDTH-1:0] r_b [0:N];

    logic                   r_g_v;
    t_class                 r_g_c;
    logic [COORD_WIDTH-1:0] r_g_b;
    logic [AW-1:0]          r_g_a;
    logic [HW-1:0]          r_hi, r_lo;

    logic                   r_out_v;
    logic [MW-1:0]          r_mag;
    logic [ANG_WIDTH-1:0]   r_ang;
    logic                   r_zero;

    logic [DW-2:0]          ux;
    logic [HW-1:0]          hi_p, lo_p;
    logic                   z_neg, z_over;
    logic [AW-1:0]          a_c, a_sel;

    logic [PW-1:0]          p;
    logic [MW-1:0]          mag_c;
    logic [TW-1:0]          t, rnd;
    logic [ANG_WIDTH-1:0]   ang_r, ang_c;

    assign en      = !r_out_v || i_ready;
    assign o_ready = en;

    // load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= DW'({i_ax, {GUARD_BITS{1'b0}}});
            r_y[0] <= DW'({i_ay, {GUARD_BITS{1'b0}}});
            r_z[0] <= '0;
            r_c[0] <= i_cls;
            r_b[0] <= (i_cls.kind == KIND_YAXIS) ? i_ay : i_ax;
        end
    end

    // vectoring iterations, one per stage
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [DW-1:0] xs, ys;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else if (en) begin
                r_v[i+1] <= r_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (!r_y[i][DW-1]) begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + ZW'(atan_q16(i));
                end else begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - ZW'(atan_q16(i));
                end
                r_c[i+1] <= r_c[i];
                r_b[i+1] <= r_b[i];
            end
        end
    end

    // clamp angle, gain partial products
    always_comb begin
        ux     = r_x[N][DW-1] ? '0 : r_x[N][DW-2:0];
        hi_p   = HW'(ux) * HW'(GAIN_HI);
        lo_p   = HW'(ux) * HW'(GAIN_LO);
        z_neg  = r_z[N][ZW-1];
        z_over = !z_neg && (r_z[N][ZW-2:0] > (ZW-1)'(RIGHT_ANGLE));
        if (z_neg) begin
            a_c = '0;
        end else if (z_over) begin
            a_c = RIGHT_ANGLE;
        end else begin
            a_c = r_z[N][AW-1:0];
        end
        case (r_c[N].kind)
            KIND_XAXIS: a_sel = '0;
            KIND_YAXIS: a_sel = RIGHT_ANGLE;
            default:    a_sel = a_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (en) begin
            r_g_v <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_c <= r_c[N];
            r_g_b <= r_b[N];
            r_g_a <= a_sel;
            r_hi  <= hi_p;
            r_lo  <= lo_p;
        end
    end

    // magnitude rounding, quadrant restore
    always_comb begin
        p     = PW'(r_hi) + PW'(r_lo >> GAIN_SPLIT) + (PW'(1) << (MAG_SHIFT - 1));
        mag_c = p[MAG_SHIFT +: MW];
        case ({r_g_c.dx_neg, r_g_c.dy_neg})
            2'b10:   t = HALF_TURN - TW'(r_g_a);
            2'b11:   t = HALF_TURN + TW'(r_g_a);
            2'b01:   t = FULL_TURN - TW'(r_g_a);
            default: t = TW'(r_g_a);
        endcase
        rnd   = t + ANGLE_ROUND;
        ang_r = rnd[ANGLE_SHIFT +: ANG_WIDTH];
        ang_c = (ang_r >= FULL_TURN_OUT) ? ang_r - FULL_TURN_OUT : ang_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_g_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_g_c.kind)
                KIND_ZERO: begin
                    r_mag  <= '0;
                    r_ang  <= '0;
                    r_zero <= 1'b1;
                end
                KIND_XAXIS, KIND_YAXIS: begin
                    r_mag  <= MW'(r_g_b);
                    r_ang  <= ang_c;
                    r_zero <= 1'b0;
                end
                default: begin
                    r_mag  <= mag_c;
                    r_ang  <= ang_c;
                    r_zero <= 1'b0;
                end
            endcase
        end
    end

    assign o_valid     = r_out_v;
    assign o_magnitude = r_mag;
    assign o_angle     = r_ang;
    assign o_zero      = r_zero;

endmodule

// ===== design/cartesian_to_polar.sv =====
// cartesian_to_polar: length and direction of the vector between two points
//
// slave channel: one beat carries start_x, start_y, end_x, end_y, signed q8.8
// master channel: one beat carries the magnitude (unsigned q9.8), the angle
// in degrees with 7 fraction bits in [0,360), and in tuser the zero-vector flag
//
// throughput is one beat per cycle while i_m_tready stays high: an input
// register, a four-entry queue, then a CORDIC pipeline of CORDIC_STAGES
// iterations, a gain stage and the output register.
//
// a stall on i_m_tready freezes the back pipeline; the queue and the input
// register keep taking beats until the queue fills, then o_s_tready drops.
// reset empties the queue and clears every valid, so no beat is in flight
// after reset; the block is ready to take a beat as soon as reset ends.
module cartesian_to_polar #(
    parameter int COORD_WIDTH   = c2p_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2p_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_tvalid,
    output logic                                    o_s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]      i_s_tdata,
    output logic                                    o_m_tvalid,
    input  logic                                    i_m_tready,
    // magnitude, angle_degrees
    output logic [((COORD_WIDTH+1+c2p_pkg::ANG_WIDTH+7)/8)*8-1:0] o_m_tdata,
    // zero_vector
    output logic [0:0]                              o_m_tuser
);
    import c2p_pkg::*;

    localparam int OUT_TW = ((COORD_WIDTH + 1 + ANG_WIDTH + 7) / 8) * 8;
    localparam int QW     = $bits(t_class) + 2 * COORD_WIDTH;

    logic                   f_valid, f_ready;
    t_class                 f_cls;
    logic [COORD_WIDTH-1:0] f_ax, f_ay;

    logic                   q_valid, q_pop;
    logic [QW-1:0]          q_data;
    t_class                 q_cls;
    logic [COORD_WIDTH-1:0] q_ax, q_ay;

    logic [COORD_WIDTH:0]   mag;
    logic [ANG_WIDTH-1:0]   ang;
    logic                   zero;

    c2p_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_start_x (i_s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
        .i_start_y (i_s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
        .i_end_x   (i_s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
        .i_end_y   (i_s_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
        .o_valid   (f_valid),
        .i_ready   (f_ready),
        .o_cls     (f_cls),
        .o_ax      (f_ax),
        .o_ay      (f_ay)
    );

    c2p_fifo #(
        .WIDTH (QW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_cls, f_ax, f_ay}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign {q_cls, q_ax, q_ay} = q_data;

    c2p_back #(
        .COORD_WIDTH   (COORD_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_pop),
        .i_cls       (q_cls),
        .i_ax        (q_ax),
        .i_ay        (q_ay),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_magnitude (mag),
        .o_angle     (ang),
        .o_zero      (zero)
    );

    assign o_m_tdata = OUT_TW'({ang, mag});
    assign o_m_tuser = zero;

endmodule

// ===== sim/cartesian_to_polar_tb.sv =====
`timescale 1ns / 1ps

module cartesian_to_polar_tb;

    localparam int STAGES         = 16;
    localparam int GUARD          = 12;
    localparam int RAND_PER_PHASE = 360;
    localparam int N_DIR          = 24;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;

    localparam longint RIGHT_Q16  = 90 * 65536;
    localparam longint HALF_Q16   = 180 * 65536;
    localparam longint TURN_OUT   = 360 * 128;
    localparam longint K_Q30      = 652032874;
    localparam longint K_HI       = K_Q30 >> 15;
    localparam longint K_LO       = K_Q30 & 32767;

    localparam logic [15:0] ANG_0   = 16'd0;
    localparam logic [15:0] ANG_90  = 16'd11520;
    localparam logic [15:0] ANG_180 = 16'd23040;
    localparam logic [15:0] ANG_270 = 16'd34560;

    typedef struct packed {
        logic [16:0] mag;
        logic [15:0] ang;
        logic        zv;
    } t_polar;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        pinned;
        t_polar      res;
    } t_vec_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // start_x, start_y, end_x, end_y
    logic [63:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // magnitude, angle_degrees
    logic [39:0] o_m_tdata;
    // zero_vector
    logic [0:0]  o_m_tuser;

    // expected result riding along with a beat whose answer is typed in
    logic        pinned_flag = 1'b0;
    t_polar      pinned_res = '0;

    int unsigned atan_deg_q16 [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    t_polar   polar_q [$];
    t_vec_row dir_tbl [N_DIR];
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       mismatches = 0;
    int       beats_in = 0;
    int       results_seen = 0;
    int       zero_seen = 0;
    int       quiet = 0;
    int       idle_pct [4] = '{0, 66, 0, 16};
    int       stall_pct [4] = '{0, 0, 66, 16};

    always #4 i_clk = ~i_clk;

    cartesian_to_polar DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    function automatic t_polar polar_of(input logic signed [15:0] sx, input logic signed [15:0] sy,
                                        input logic signed [15:0] ex, input logic signed [15:0] ey);
        longint dx, dy, ax, ay, x, y, z, xs, ys, a, t, mag, ang, p;
        int     i;
        t_polar r;
        r = '0;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        if (dx == 0 && dy == 0) begin
            r.zv = 1'b1;
            return r;
        end
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        if (ay == 0) begin
            mag = ax;
            a = 0;
        end else if (ax == 0) begin
            mag = ay;
            a = RIGHT_Q16;
        end else begin
            x = ax <<< GUARD;
            y = ay <<< GUARD;
            z = 0;
            for (i = 0; i < STAGES; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + longint'(atan_deg_q16[i]);
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - longint'(atan_deg_q16[i]);
                end
            end
            if (z < 0) z = 0;
            if (z > RIGHT_Q16) z = RIGHT_Q16;
            a = z;
            if (x < 0) x = 0;
            p = x * K_HI + ((x * K_LO) >>> 15);
            mag = (p + (longint'(1) <<< 26)) >>> 27;
        end
        if (dx >= 0 && dy >= 0) t = a;
        else if (dx < 0 && dy >= 0) t = HALF_Q16 - a;
        else if (dx < 0) t = HALF_Q16 + a;
        else t = 2 * HALF_Q16 - a;
        ang = (t + 256) >>> 9;
        if (ang >= TURN_OUT) ang = ang - TURN_OUT;
        r.mag = mag[16:0];
        r.ang = ang[15:0];
        return r;
    endfunction

    task automatic report_mismatch(input string why, input t_polar want, input t_polar got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display({"mismatch (%s) at %0t: expected mag %0d ang %0d zero %0d,",
                      " got mag %0d ang %0d zero %0d"},
                     why, $time, want.mag, want.ang, want.zv, got.mag, got.ang, got.zv);
    endtask

    task automatic send_coords(input logic [15:0] sx, input logic [15:0] sy,
                               input logic [15:0] ex, input logic [15:0] ey,
                               input logic pinned, input t_polar res);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= {ey, ex, sy, sx};
        pinned_flag <= pinned;
        pinned_res  <= res;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (polar_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_polar want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                beats_in++;
                if (pinned_flag) polar_q.push_back(pinned_res);
                else polar_q.push_back(polar_of(i_s_tdata[15:0], i_s_tdata[31:16],
                                                i_s_tdata[47:32], i_s_tdata[63:48]));
            end
            if (o_m_tvalid && i_m_tready) begin
                got.mag = o_m_tdata[16:0];
                got.ang = o_m_tdata[32:17];
                got.zv  = o_m_tuser[0];
                results_seen++;
                if (got.zv) zero_seen++;
                if (polar_q.size() == 0) begin
                    report_mismatch("no result pending", '0, got);
                end else begin
                    want = polar_q.pop_front();
                    if (got.mag != want.mag || got.ang != want.ang || got.zv != want.zv)
                        report_mismatch("wrong field", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    logic [15:0] rsx, rsy, rex, rey, pick [5];
    int          kind, d, ph, n;

    initial begin
        pick = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
        dir_tbl = '{
            '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{17'd0, ANG_0, 1'b1}},
            '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, '{17'd0, ANG_0, 1'b1}},
            '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1, '{17'd0, ANG_0, 1'b1}},
            '{16'h0000, 16'h0000, 16'h0100, 16'h0000, 1'b1, '{17'd256, ANG_0, 1'b0}},
            '{16'h0000, 16'h0000, 16'hff00, 16'h0000, 1'b1, '{17'd256, ANG_180, 1'b0}},
            '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 1'b1, '{17'd256, ANG_90, 1'b0}},
            '{16'h0000, 16'h0000, 16'h0000, 16'hff00, 1'b1, '{17'd256, ANG_270, 1'b0}},
            '{16'h8000, 16'h0000, 16'h7fff, 16'h0000, 1'b1, '{17'd65535, ANG_0, 1'b0}},
            '{16'h7fff, 16'h0000, 16'h8000, 16'h0000, 1'b1, '{17'd65535, ANG_180, 1'b0}},
            '{16'h0000, 16'h8000, 16'h0000, 16'h7fff, 1'b1, '{17'd65535, ANG_90, 1'b0}},
            '{16'h0000, 16'h7fff, 16'h0000, 16'h8000, 1'b1, '{17'd65535, ANG_270, 1'b0}},
            '{16'h0005, 16'h0000, 16'h0006, 16'h0000, 1'b1, '{17'd1, ANG_0, 1'b0}},
            '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1'b0, '0},
            '{16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, '0},
            '{16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1'b0, '0},
            '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'hffff, 16'h0001, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 1'b0, '0},
            '{16'h0000, 16'h0000, 16'h0001, 16'hffff, 1'b0, '0},
            // just below the positive x axis, rounds to a full turn
            '{16'h8000, 16'h0000, 16'h7fff, 16'hffff, 1'b0, '0},
            '{16'h8000, 16'h0000, 16'h7fff, 16'h0001, 1'b0, '0},
            // steep vectors that push the cordic angle past 90
            '{16'h0000, 16'h8000, 16'h0001, 16'h7fff, 1'b0, '0},
            '{16'h0000, 16'h7fff, 16'hffff, 16'h8000, 1'b0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (d = 0; d < N_DIR; d++)
            send_coords(dir_tbl[d].sx, dir_tbl[d].sy, dir_tbl[d].ex, dir_tbl[d].ey,
                        dir_tbl[d].pinned, dir_tbl[d].res);
        drain_results();

        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (n = 0; n < RAND_PER_PHASE; n++) begin
                kind = $urandom_range(99);
                rsx = 16'($urandom);
                rsy = 16'($urandom);
                rex = 16'($urandom);
                rey = 16'($urandom);
                if (kind < 60) begin
                end else if (kind < 70) begin
                    rex = rsx + 16'($signed($urandom_range(16)) - 8);
                    rey = rsy + 16'($signed($urandom_range(16)) - 8);
                end else if (kind < 80) begin
                    rey = rsy;
                end else if (kind < 88) begin
                    rex = rsx;
                end else if (kind < 93) begin
                    rex = rsx;
                    rey = rsy;
                end else begin
                    rsx = pick[$urandom_range(4)];
                    rsy = pick[$urandom_range(4)];
                    rex = pick[$urandom_range(4)];
                    rey = pick[$urandom_range(4)];
                end
                send_coords(rsx, rsy, rex, rey, 1'b0, '0);
            end
            // hold off until the pipeline is empty before the next phase
            drain_results();
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d vectors (directed extremes, axes, zero vectors, random) under four",
                 beats_in);
        $display("handshake mixes; checked %0d results, %0d of them zero vectors",
                 results_seen, zero_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
